[rtl/core/bitmap_frame_allocator_macros.svh]
// assertion macros for the bitmap frame allocator
// used by files that check their own logic; no other dependencies
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa check failed");

// next-cycle implication, disabled in reset
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa check failed");

`endif

[rtl/core/bfa_pkg.sv]
// shared types, constants and helper functions of the bitmap frame allocator
// no dependencies
package bfa_pkg;

  localparam int MAX_FRAMES    = 65536;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = MAX_FRAMES / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int FRAME_W       = 16;
  localparam int COUNT_W       = 17;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int PADDR_W       = 3;

  localparam logic [COUNT_W-1:0] MAX_FRAMES_C = COUNT_W'(MAX_FRAMES);
  localparam logic [PADDR_W-3:0] REG_FRAME_COUNT = '0;

  typedef logic [MAP_WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_ALLOC_ONE = 3'd0,
    ACT_FREE_ONE  = 3'd1,
    ACT_ALLOC_RUN = 3'd2,
    ACT_FREE_RUN  = 3'd3,
    ACT_LOAD_FREE = 3'd4,
    ACT_RESERVE   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NONE_AVAIL  = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_IGNORED     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EV
  } state_t;

  typedef enum logic [2:0] {
    W_ALLOC1,
    W_SEARCH,
    W_MARK,
    W_FREE,
    W_LOAD,
    W_RESERVE
  } walk_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [FRAME_W-1:0] frame_num;
    logic [COUNT_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_frames;
  } rsp_t;

  // index of lowest set bit, MAP_WORD_BITS when none
  function automatic logic [BIT_W:0] first_one(input word_t v);
    logic [BIT_W:0] r;
    r = (BIT_W+1)'(MAP_WORD_BITS);
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = (BIT_W+1)'(i);
    end
    return r;
  endfunction

  // number of set bits from the msb down to the first clear bit
  function automatic logic [BIT_W:0] lead_ones(input word_t v);
    logic [BIT_W:0] r;
    r = (BIT_W+1)'(MAP_WORD_BITS);
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      if (!v[i]) r = (BIT_W+1)'(MAP_WORD_BITS - 1 - i);
    end
    return r;
  endfunction

  // bits of word w whose frame lies in [lo, hix)
  function automatic word_t range_mask(input logic [WORD_AW-1:0] w,
                                       input logic [COUNT_W-1:0] lo,
                                       input logic [COUNT_W-1:0] hix);
    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] top;
    word_t lm;
    word_t um;
    base = {1'b0, w, {BIT_W{1'b0}}};
    top  = base + COUNT_W'(MAP_WORD_BITS);
    if (lo <= base) lm = '1;
    else if (lo >= top) lm = '0;
    else lm = '1 << lo[BIT_W-1:0];
    if (hix >= top) um = '1;
    else if (hix <= base) um = '0;
    else um = ~('1 << hix[BIT_W-1:0]);
    return lm & um;
  endfunction

  // bit i set when a free run of length len ends at bit i (len up to one word)
  function automatic logic [2*MAP_WORD_BITS-1:0] run_ends(
      input logic [2*MAP_WORD_BITS-1:0] v, input logic [BIT_W:0] len);
    logic [2*MAP_WORD_BITS-1:0] a [BIT_W+1];
    logic [2*MAP_WORD_BITS-1:0] r;
    a[0] = v;
    for (int k = 1; k <= BIT_W; k++) begin
      a[k] = a[k-1] & (a[k-1] << (1 << (k - 1)));
    end
    r = '1;
    for (int k = 0; k <= BIT_W; k++) begin
      if (len[k]) r = a[k] & (r << (1 << k));
    end
    return r;
  endfunction

endpackage

[rtl/core/bitmap_frame_allocator.sv]
// Immediate cases finish from idle; otherwise each map word walked takes a read and an evaluate state.
// Single frame free, load and reserve walk one map word; alloc scans up to 2 passes
// of 64-frame words; run alloc scans then marks the run word by word.
// One request at a time, the next taken in the cycle its result shows; no result stall.
// Reset (synchronous): a clearing pass writes every map word to all used;
// start is held off (busy) until it ends, configuration writes still land.
module bitmap_frame_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bfa_pkg::req_t                 request,
  output logic                          done,
  output bfa_pkg::rsp_t                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bfa_pkg::*;
  `include "bitmap_frame_allocator_macros.svh"

  state_t              state, state_next;
  walk_t               mode, mode_next;
  logic [WORD_AW-1:0]  clr_cnt;
  logic [WORD_AW-1:0]  w, w_next;
  logic [COUNT_W-1:0]  lo, lo_next;
  logic [COUNT_W-1:0]  hix, hix_next;
  logic [COUNT_W-1:0]  len, len_next;
  logic [BIT_W-1:0]    bitsel, bitsel_next;
  logic                phase1, phase1_next;
  logic [COUNT_W-1:0]  hint, hint_next;
  logic [COUNT_W-1:0]  total, total_next;
  word_t               prev_free, prev_free_next;
  logic [COUNT_W-1:0]  run_r, run_r_next;
  logic [COUNT_W-1:0]  frame_count;

  logic                fin, go_rd;
  logic [FRAME_W-1:0]  fin_res;
  status_t             fin_st;

  logic                ram_we;
  logic [WORD_AW-1:0]  ram_waddr;
  word_t               ram_wdata, rdata;

  logic [COUNT_W-1:0]  n;
  logic [COUNT_W-1:0]  nm1;
  logic                accept;

  // effective frame count
  assign n      = (frame_count > MAX_FRAMES_C) ? MAX_FRAMES_C : frame_count;
  assign nm1    = n - COUNT_W'(1);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_FRAME_COUNT) ? {15'd0, frame_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= MAX_FRAMES_C;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_FRAME_COUNT) begin
      frame_count <= pwdata[COUNT_W-1:0];
    end
  end

  // used map storage
  bfa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == WORD_AW'(MAP_WORDS - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept && go_rd) state_next = S_RD;
      S_RD:    state_next = S_EV;
      S_EV:    state_next = go_rd ? S_RD : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // word evaluation helpers
  logic [COUNT_W-1:0]         base;
  word_t                      mask_n, used_eff, free_w, rmask, cand;
  logic [BIT_W:0]             cand_i, bad_i, end_i, tail_p, top_p;
  logic [2*MAP_WORD_BITS-1:0] ends;
  logic                       last_scan, last_rng;
  logic [COUNT_W-1:0]         flen, fsum, fstart;

  always_comb begin
    base      = {1'b0, w, {BIT_W{1'b0}}};
    mask_n    = range_mask(w, '0, n);
    used_eff  = rdata | ~mask_n;
    free_w    = ~used_eff;
    rmask     = range_mask(w, lo, hix);
    cand      = free_w & range_mask(w, lo, MAX_FRAMES_C);
    cand_i    = first_one(cand);
    bad_i     = first_one(~rdata & rmask);
    ends      = run_ends({free_w, prev_free}, len[BIT_W:0]);
    end_i     = first_one(ends[2*MAP_WORD_BITS-1:MAP_WORD_BITS]);
    tail_p    = first_one(~free_w);
    top_p     = lead_ones(free_w);
    last_scan = (w == nm1[FRAME_W-1:BIT_W]);
    fsum      = hix - COUNT_W'(1);
    last_rng  = (w == fsum[FRAME_W-1:BIT_W]);
    flen      = (request.action == ACT_FREE_ONE) ? COUNT_W'(1) : request.run_length;
    fstart    = base + COUNT_W'(end_i) + COUNT_W'(1) - len;
  end

  // datapath and outputs
  always_comb begin
    logic [COUNT_W:0]   fend;
    logic [COUNT_W-1:0] stop;
    mode_next      = mode;
    w_next         = w;
    lo_next        = lo;
    hix_next       = hix;
    len_next       = len;
    bitsel_next    = bitsel;
    phase1_next    = phase1;
    hint_next      = hint;
    total_next     = total;
    prev_free_next = prev_free;
    run_r_next     = run_r;
    fin            = 1'b0;
    go_rd          = 1'b0;
    fin_res        = '0;
    fin_st         = ST_OK;
    ram_we         = 1'b0;
    ram_waddr      = w;
    ram_wdata      = rdata;
    fend           = '0;
    stop           = '0;

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '1;
      end

      S_IDLE: begin
        if (accept) begin
          len_next    = request.run_length;
          bitsel_next = request.frame_num[BIT_W-1:0];
          case (request.action)
            ACT_ALLOC_ONE, ACT_ALLOC_RUN: begin
              if (request.action == ACT_ALLOC_RUN && request.run_length == '0) begin
                fin    = 1'b1;
                fin_st = ST_IGNORED;
              end else if (request.action == ACT_ALLOC_RUN && request.run_length > n) begin
                fin    = 1'b1;
                fin_st = ST_NONE_AVAIL;
              end else if (request.action == ACT_ALLOC_RUN &&
                           request.run_length != COUNT_W'(1)) begin
                // first-fit run search from frame zero
                mode_next      = W_SEARCH;
                w_next         = '0;
                prev_free_next = '0;
                run_r_next     = '0;
                go_rd          = 1'b1;
              end else if (n == '0) begin
                fin       = 1'b1;
                fin_st    = ST_NONE_AVAIL;
                hint_next = '0;
              end else begin
                // next-fit from the hint, or a full pass from zero
                mode_next = W_ALLOC1;
                go_rd     = 1'b1;
                if (hint < n) begin
                  phase1_next = 1'b1;
                  lo_next     = hint;
                  w_next      = hint[FRAME_W-1:BIT_W];
                end else begin
                  phase1_next = 1'b0;
                  lo_next     = '0;
                  w_next      = '0;
                end
              end
            end
            ACT_FREE_ONE, ACT_FREE_RUN: begin
              // end of the walk, one bit wider so a long run cannot wrap
              fend = (COUNT_W+1)'(request.frame_num) + (COUNT_W+1)'(flen);
              if (fend > (COUNT_W+1)'(n)) fend = (COUNT_W+1)'(n);
              if (request.frame_num == '0 || flen == '0) begin
                fin    = 1'b1;
                fin_st = ST_IGNORED;
              end else if (COUNT_W'(request.frame_num) >= n) begin
                // nothing in the map; only the hint moves
                fin = 1'b1;
                if (COUNT_W'(request.frame_num) < hint)
                  hint_next = COUNT_W'(request.frame_num);
              end else begin
                mode_next = W_FREE;
                lo_next   = COUNT_W'(request.frame_num);
                hix_next  = fend[COUNT_W-1:0];
                w_next    = request.frame_num[FRAME_W-1:BIT_W];
                go_rd     = 1'b1;
              end
            end
            ACT_LOAD_FREE, ACT_RESERVE: begin
              if (COUNT_W'(request.frame_num) < n) begin
                mode_next = (request.action == ACT_LOAD_FREE) ? W_LOAD : W_RESERVE;
                w_next    = request.frame_num[FRAME_W-1:BIT_W];
                go_rd     = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = ST_IGNORED;
            end
          endcase
        end
      end

      S_EV: begin
        case (mode)
          W_ALLOC1: begin
            if (cand_i != (BIT_W+1)'(MAP_WORD_BITS)) begin
              ram_we    = 1'b1;
              ram_wdata = rdata | (word_t'(1) << cand_i[BIT_W-1:0]);
              total_next = total - COUNT_W'(1);
              hint_next  = base + COUNT_W'(cand_i) + COUNT_W'(1);
              fin        = 1'b1;
              fin_res    = FRAME_W'(base + COUNT_W'(cand_i));
            end else if (!last_scan) begin
              w_next = w + WORD_AW'(1);
              go_rd  = 1'b1;
            end else if (phase1) begin
              phase1_next = 1'b0;
              lo_next     = '0;
              w_next      = '0;
              go_rd       = 1'b1;
            end else begin
              hint_next = '0;
              fin       = 1'b1;
              fin_st    = ST_NONE_AVAIL;
            end
          end

          W_SEARCH: begin
            if (len <= COUNT_W'(MAP_WORD_BITS)) begin
              // run fits in this word and the one before
              if (end_i != (BIT_W+1)'(MAP_WORD_BITS)) begin
                mode_next = W_MARK;
                lo_next   = fstart;
                hix_next  = fstart + len;
                w_next    = fstart[FRAME_W-1:BIT_W];
                go_rd     = 1'b1;
              end
            end else if (run_r != '0 && run_r + COUNT_W'(tail_p) >= len) begin
              mode_next = W_MARK;
              lo_next   = base - run_r;
              hix_next  = base - run_r + len;
              w_next    = lo_next[FRAME_W-1:BIT_W];
              go_rd     = 1'b1;
            end
            if (!go_rd) begin
              prev_free_next = free_w;
              run_r_next     = (free_w == '1) ? run_r + COUNT_W'(MAP_WORD_BITS)
                                              : COUNT_W'(top_p);
              if (last_scan) begin
                fin    = 1'b1;
                fin_st = ST_NONE_AVAIL;
              end else begin
                w_next = w + WORD_AW'(1);
                go_rd  = 1'b1;
              end
            end
          end

          W_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = rdata | rmask;
            if (last_rng) begin
              total_next = total - len;
              fin        = 1'b1;
              fin_res    = lo[FRAME_W-1:0];
            end else begin
              w_next = w + WORD_AW'(1);
              go_rd  = 1'b1;
            end
          end

          W_FREE: begin
            ram_we = 1'b1;
            if (bad_i != (BIT_W+1)'(MAP_WORD_BITS)) begin
              // stop at the frame that is already free
              stop      = base + COUNT_W'(bad_i);
              ram_wdata = rdata & ~(rmask & ~('1 << bad_i[BIT_W-1:0]));
              total_next = total + (stop - lo);
              fin        = 1'b1;
              fin_st     = ST_DOUBLE_FREE;
              fin_res    = stop[FRAME_W-1:0];
              if (stop != lo && lo < hint) hint_next = lo;
            end else begin
              ram_wdata = rdata & ~rmask;
              if (last_rng) begin
                total_next = total + (hix - lo);
                fin        = 1'b1;
                if (lo < hint) hint_next = lo;
              end else begin
                w_next = w + WORD_AW'(1);
                go_rd  = 1'b1;
              end
            end
          end

          W_LOAD: begin
            ram_we    = 1'b1;
            ram_wdata = rdata & ~(word_t'(1) << bitsel);
            if (rdata[bitsel]) total_next = total + COUNT_W'(1);
            fin = 1'b1;
          end

          W_RESERVE: begin
            ram_we    = 1'b1;
            ram_wdata = rdata | (word_t'(1) << bitsel);
            if (!rdata[bitsel]) total_next = total - COUNT_W'(1);
            fin = 1'b1;
          end

          default: begin
            fin    = 1'b1;
            fin_st = ST_IGNORED;
          end
        endcase
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      hint    <= '0;
      total   <= '0;
      done    <= 1'b0;
      mode    <= W_ALLOC1;
      phase1  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= (state == S_CLEAR) ? clr_cnt + WORD_AW'(1) : clr_cnt;
      hint    <= hint_next;
      total   <= total_next;
      done    <= fin;
      mode    <= mode_next;
      phase1  <= phase1_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w         <= w_next;
    lo        <= lo_next;
    hix       <= hix_next;
    len       <= len_next;
    bitsel    <= bitsel_next;
    prev_free <= prev_free_next;
    run_r     <= run_r_next;
    if (fin) begin
      result.result_frame <= fin_res;
      result.status       <= fin_st;
      result.free_frames  <= total_next;
    end
  end

  // checks
  `BFA_ASSERT_NOW(a_free_bound, clk, rst, done, result.free_frames <= MAX_FRAMES_C)
  `BFA_ASSERT_NOW(a_clear_busy, clk, rst, state == S_CLEAR, busy && !done)
  `BFA_ASSERT_NOW(a_dbl_nonzero, clk, rst, done && result.status == ST_DOUBLE_FREE,
                  result.result_frame != '0)
  `BFA_ASSERT_NEXT(a_single_done, clk, rst, state == S_EV && (mode == W_LOAD || mode == W_RESERVE),
                   done && state == S_IDLE)

endmodule

[rtl/core/bfa_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[bench/bfa_checker.sv]
// request/result checker for the bitmap frame allocator: predicts each result and compares
// depends on bfa_pkg for the request, result and code types
`timescale 1ns / 100ps

module bfa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  bfa_pkg::req_t               request,
  input  logic                        done,
  input  bfa_pkg::rsp_t               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fails,
  output int                          pending
);
  import bfa_pkg::*;

  // shadow copy of the allocator state
  bit          frame_used [MAX_FRAMES];
  int unsigned hint;
  int unsigned free_cnt;
  int unsigned frame_cnt;
  rsp_t        expected_q [$];

  function automatic int unsigned covered();
    return (frame_cnt > MAX_FRAMES) ? MAX_FRAMES : frame_cnt;
  endfunction

  function automatic bit used_at(int unsigned f);
    if (f >= covered()) return 1'b1;
    return frame_used[f];
  endfunction

  function automatic void take(int unsigned f);
    if (f < covered() && !frame_used[f]) begin
      frame_used[f] = 1'b1;
      free_cnt--;
    end
  endfunction

  function automatic void give(int unsigned f);
    if (f < covered() && frame_used[f]) begin
      frame_used[f] = 1'b0;
      free_cnt++;
    end
  endfunction

  // next-fit scan from the hint, then one wrap from frame zero
  function automatic bit next_fit(output int unsigned got);
    int unsigned n;
    n = covered();
    got = 0;
    for (int unsigned f = hint; f < n; f++) begin
      if (!used_at(f)) begin
        take(f);
        hint = f + 1;
        got = f;
        return 1'b1;
      end
    end
    hint = 0;
    for (int unsigned f = 0; f < n; f++) begin
      if (!used_at(f)) begin
        take(f);
        hint = f + 1;
        got = f;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t allocate(req_t r);
    rsp_t        e;
    int unsigned n, idx, len, got, first, run, f;
    bit          found;
    n = covered();
    idx = r.frame_num;
    len = r.run_length;
    e.result_frame = '0;
    e.status = ST_OK;
    case (r.action)
      ACT_ALLOC_ONE: begin
        if (next_fit(got)) e.result_frame = got[15:0];
        else e.status = ST_NONE_AVAIL;
      end
      ACT_FREE_ONE: begin
        if (idx == 0) e.status = ST_IGNORED;
        else if (idx < n && !used_at(idx)) begin
          e.status = ST_DOUBLE_FREE;
          e.result_frame = idx[15:0];
        end else begin
          give(idx);
          if (idx < hint) hint = idx;
        end
      end
      ACT_ALLOC_RUN: begin
        if (len == 0) e.status = ST_IGNORED;
        else if (len > n) e.status = ST_NONE_AVAIL;
        else if (len == 1) begin
          if (next_fit(got)) e.result_frame = got[15:0];
          else e.status = ST_NONE_AVAIL;
        end else begin
          // first-fit run search from frame zero
          first = 0;
          run = 0;
          found = 1'b0;
          for (f = 0; f < n; f++) begin
            if (used_at(f)) run = 0;
            else begin
              if (run == 0) first = f;
              run++;
              if (run == len) begin
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            for (f = first; f < first + len; f++) take(f);
            e.result_frame = first[15:0];
          end else e.status = ST_NONE_AVAIL;
        end
      end
      ACT_FREE_RUN: begin
        if (idx == 0 || len == 0) e.status = ST_IGNORED;
        else begin
          found = 1'b0;
          for (int unsigned i = 0; i < len; i++) begin
            f = idx + i;
            if (f >= n) break;
            if (!used_at(f)) begin
              e.status = ST_DOUBLE_FREE;
              e.result_frame = f[15:0];
              found = (i == 0);
              break;
            end
            give(f);
          end
          if (!found && idx < hint) hint = idx;
        end
      end
      ACT_LOAD_FREE: give(idx);
      ACT_RESERVE:   take(idx);
      default:       e.status = ST_IGNORED;
    endcase
    e.free_frames = free_cnt[COUNT_W-1:0];
    return e;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  // watch both channels and the register port
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) frame_used[i] = 1'b1;
      hint = 0;
      free_cnt = 0;
      frame_cnt = MAX_FRAMES;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report("result with no request", result.result_frame, -1);
        end else begin
          e = expected_q.pop_front();
          if (result.result_frame !== e.result_frame)
            report("result_frame", result.result_frame, e.result_frame);
          if (result.status !== e.status)
            report("status", result.status, e.status);
          if (result.free_frames !== e.free_frames)
            report("free_frames", result.free_frames, e.free_frames);
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_FRAME_COUNT)
        frame_cnt = pwdata[COUNT_W-1:0];
      if (start && !busy) expected_q.push_back(allocate(request));
    end
    pending <= expected_q.size();
  end
endmodule

[bench/tb.sv]
// top of the bitmap frame allocator bench: clock, reset, requests and register writes
// depends on bfa_pkg, bfa_checker and the allocator itself
`timescale 1ns / 100ps

module tb;
  import bfa_pkg::*;

  localparam int LIMIT = 8000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 request = '0;
  logic                 done;
  rsp_t                 result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fails;
  int                   pending;
  int                   cycles = 0;
  bit                   gaps_on = 1'b1;
  int unsigned          cur_count = MAX_FRAMES;

  bitmap_frame_allocator DUT (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bfa_checker u_checker (
    .clk, .rst, .start, .busy, .request, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fails, .pending
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one request, held until accepted, then maybe a sender gap
  task automatic send(logic [2:0] act, int unsigned idx, int unsigned len);
    start <= 1'b1;
    request <= '{action: act, frame_num: idx[15:0], run_length: len[16:0]};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // wait until every request has its result
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FRAME_COUNT, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_count = (value[16:0] > MAX_FRAMES) ? MAX_FRAMES : value[16:0];
    @(posedge clk);
  endtask

  // random request mostly within the covered frames
  task automatic random_request();
    int unsigned pick, idx, len, span;
    logic [2:0]  act;
    span = (cur_count + 3 > 65535) ? 65535 : cur_count + 3;
    pick = $urandom_range(0, 99);
    if (pick < 30) act = ACT_ALLOC_ONE;
    else if (pick < 45) act = ACT_FREE_ONE;
    else if (pick < 60) act = ACT_ALLOC_RUN;
    else if (pick < 70) act = ACT_FREE_RUN;
    else if (pick < 88) act = ACT_LOAD_FREE;
    else if (pick < 96) act = ACT_RESERVE;
    else act = 3'($urandom_range(6, 7));
    pick = $urandom_range(0, 99);
    if (pick < 85) idx = $urandom_range(0, span);
    else if (pick < 95) idx = $urandom_range(0, 65535);
    else idx = 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(1, 8);
    else if (pick < 85) len = $urandom_range(0, cur_count);
    else if (pick < 90) len = 0;
    else len = $urandom_range(0, 131071);
    send(act, idx, len);
  endtask

  initial begin
    int unsigned counts [8];
    int unsigned n_items;
    counts = '{64, 1, 0, 200, 65536, 131071, 1000, 130};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // let the clearing pass finish
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: empty map, ignored cases and the top frame
    send(ACT_ALLOC_ONE, 0, 0);
    send(ACT_FREE_ONE, 0, 0);
    send(ACT_ALLOC_RUN, 5, 0);
    send(ACT_FREE_RUN, 0, 4);
    send(ACT_FREE_RUN, 9, 0);
    send(3'd6, 65535, 131071);
    send(3'd7, 1, 1);
    send(ACT_LOAD_FREE, 0, 0);
    send(ACT_ALLOC_ONE, 0, 0);
    send(ACT_LOAD_FREE, 65535, 0);
    send(ACT_RESERVE, 65535, 0);
    send(ACT_FREE_ONE, 65535, 0);
    send(ACT_FREE_ONE, 65535, 0);
    send(ACT_ALLOC_RUN, 0, 65536);
    send(ACT_ALLOC_RUN, 0, 131071);
    send(ACT_ALLOC_RUN, 0, 1);
    send(ACT_FREE_RUN, 65530, 131071);
    send(ACT_ALLOC_RUN, 0, 3);
    send(ACT_FREE_RUN, 65531, 2);
    send(ACT_FREE_RUN, 65529, 8);
    send(ACT_ALLOC_ONE, 0, 0);
    drain();

    // random phases over several frame counts, extremes included
    foreach (counts[p]) begin
      if (p == 7) gaps_on = 1'b0;
      write_count((p == 5) ? 32'hFFFE_0000 | counts[p] : counts[p]);
      n_items = (counts[p] >= 65536) ? 30 : 64;
      // seed the map with free frames so allocations get deep
      repeat (n_items / 4) send(ACT_LOAD_FREE, $urandom_range(0, cur_count), 0);
      repeat (n_items) random_request();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[bitmap_frame_allocator.f]
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bitmap_frame_allocator.sv
bench/bfa_checker.sv
bench/tb.sv
